@@ design/matrix_multiply_engine_macros.svh @@
// Assertion macros shared by the matrix multiply engine RTL.
// Every macro expects clk_i and rst_ni in the scope where it is used.
`ifndef MATRIX_MULTIPLY_ENGINE_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define MME_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define MME_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ design/mme_pkg.sv @@
// Shared types and constants of the matrix multiply engine.
// No dependencies; used by mme_mac, the top level and the bench.
`default_nettype none

package mme_pkg;

  localparam int MaxDimDefault   = 16;
  localparam int FracBitsDefault = 16;

  localparam int DIM_W  = 5;   // size registers, 0..31
  localparam int IDX_W  = 4;   // row and column indexes
  localparam int MODE_W = 2;
  localparam int VAL_W  = 32;
  localparam int CFG_IDX_W = 2;
  // room for the sum of 16 full 64-bit signed products
  localparam int ACC_W  = 2 * VAL_W + IDX_W;

  localparam logic [MODE_W-1:0] MODE_WR_A = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_B = 2'd1;
  localparam logic [MODE_W-1:0] MODE_ROW  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 5'd16;

  localparam logic signed [VAL_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] Q_MIN = 32'sh8000_0000;

  // Tag that travels with each multiply-accumulate slot.
  typedef struct packed {
    logic             vld;
    logic             first;    // first term of a column
    logic             last;     // last term of a column
    logic             row_end;  // last term of the last column
    logic             zero;     // empty inner size, force product to zero
    logic [IDX_W-1:0] col;
  } mme_tag_t;

endpackage

`default_nettype wire

@@ design/mme_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module mme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/mme_mac.sv @@
// Shared multiply-accumulate unit: product, accumulate, shift and saturate.
// Depends on mme_pkg and matrix_multiply_engine_macros.svh.
`default_nettype none

`include "matrix_multiply_engine_macros.svh"

module mme_mac #(
  parameter int FRAC_BITS = mme_pkg::FracBitsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire mme_pkg::mme_tag_t               tag_i,
  input  wire logic signed [mme_pkg::VAL_W-1:0] a_i,
  input  wire logic signed [mme_pkg::VAL_W-1:0] b_i,
  output logic                                 out_vld_o,
  output logic [mme_pkg::IDX_W-1:0]            out_col_o,
  output logic signed [mme_pkg::VAL_W-1:0]     out_value_o,
  output logic                                 out_sat_o,
  output logic                                 out_last_o
);

  import mme_pkg::*;

  mme_tag_t tag1_q, tag2_q, tag3_q;

  logic signed [2*VAL_W-1:0] prod_d, prod_q;
  logic signed [ACC_W-1:0]   acc_base, prod_ext, acc_d, acc_q;
  logic signed [ACC_W-1:0]   shifted;
  logic                      fits;
  logic                      fin;

  logic                      out_vld_q, out_sat_q, out_last_q;
  logic [IDX_W-1:0]          out_col_q;
  logic signed [VAL_W-1:0]   out_value_q, value_d;

  // tag moves along with the RAM read, the product and the sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q    <= '0;
      tag2_q    <= '0;
      tag3_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      tag1_q    <= tag_i;
      tag2_q    <= tag1_q;
      tag3_q    <= tag2_q;
      out_vld_q <= fin;
    end
  end

  always_comb begin
    if (tag1_q.zero) begin
      prod_d = '0;
    end else begin
      prod_d = a_i * b_i;
    end
  end

  always_comb begin
    if (tag2_q.first) begin
      acc_base = '0;
    end else begin
      acc_base = acc_q;
    end
    prod_ext = ACC_W'(prod_q);
    acc_d    = acc_base + prod_ext;
  end

  assign shifted = acc_q >>> FRAC_BITS;
  assign fits    = (&shifted[ACC_W-1:VAL_W-1]) | ~(|shifted[ACC_W-1:VAL_W-1]);
  assign fin     = tag3_q.vld & tag3_q.last;

  always_comb begin
    if (fits) begin
      value_d = shifted[VAL_W-1:0];
    end else if (shifted[ACC_W-1]) begin
      value_d = Q_MIN;
    end else begin
      value_d = Q_MAX;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (tag2_q.vld) begin
      acc_q <= acc_d;
    end
    if (fin) begin
      out_col_q   <= tag3_q.col;
      out_value_q <= value_d;
      out_sat_q   <= ~fits;
      out_last_q  <= tag3_q.row_end;
    end
  end

  assign out_vld_o   = out_vld_q;
  assign out_col_o   = out_col_q;
  assign out_value_o = out_value_q;
  assign out_sat_o   = out_sat_q;
  assign out_last_o  = out_last_q;

  `MME_ASSERT(a_sat_clamped, !out_vld_q || !out_sat_q || out_value_q == Q_MAX || out_value_q == Q_MIN, "saturated result not at a clamp value")
  `MME_ASSERT_NEXT(a_col_contiguous, tag2_q.vld && !tag2_q.last, tag2_q.vld && !tag2_q.first, "column terms not back to back")

endmodule

`default_nettype wire

@@ design/matrix_multiply_engine.sv @@
// Matrix multiply engine top level: size registers, A and B stores, row sequencer.
// Depends on mme_pkg, mme_ram, mme_mac and matrix_multiply_engine_macros.svh.
// A write completes in the accepting cycle; a row holds busy until its last column
// leaves; one term per cycle on the single shared multiplier; results as columns end.
// Reset: rst_ni clears the sequencer and sets M, K, N to 16; stores are not cleared.
`default_nettype none

`include "matrix_multiply_engine_macros.svh"

module matrix_multiply_engine #(
  parameter int MAX_DIM   = mme_pkg::MaxDimDefault,
  parameter int FRAC_BITS = mme_pkg::FracBitsDefault
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // command side
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [mme_pkg::MODE_W-1:0]        mode_i,
  input  wire logic [mme_pkg::IDX_W-1:0]         row_index_i,
  input  wire logic [mme_pkg::IDX_W-1:0]         col_index_i,
  input  wire logic signed [mme_pkg::VAL_W-1:0]  element_value_i,
  // size registers
  input  wire logic                              cfg_we_i,
  input  wire logic [mme_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [mme_pkg::DIM_W-1:0]         cfg_wdata_i,
  // results, one cycle each
  output logic                                   result_valid_o,
  output logic [mme_pkg::IDX_W-1:0]              result_col_o,
  output logic signed [mme_pkg::VAL_W-1:0]       product_value_o,
  output logic                                   saturated_o,
  output logic                                   last_of_row_o
);

  import mme_pkg::*;

  localparam int Depth  = MAX_DIM * MAX_DIM;
  localparam int AW     = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int DimCap = (MAX_DIM < 16) ? MAX_DIM : 16;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [DIM_W-1:0] rows_q, inner_q, cols_q;
  logic [DIM_W-1:0] m_eff, k_eff, n_eff;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] row_q, row_d;
  logic [IDX_W-1:0] kc_q, kc_d;
  logic [IDX_W-1:0] jc_q, jc_d;

  logic go, wr_a, wr_b, row_go;
  logic last_k, last_j;
  logic [AW-1:0] waddr, a_raddr, b_raddr;
  logic [VAL_W-1:0] a_rdata, b_rdata;
  mme_tag_t tag;

  // ---------------------------------------------------------------------------
  // Size registers; effective size is clamped to the store dimension, at most 16.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q  <= DIM_RESET;
      inner_q <= DIM_RESET;
      cols_q  <= DIM_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ROWS:  rows_q  <= cfg_wdata_i;
        REG_INNER: inner_q <= cfg_wdata_i;
        REG_COLS:  cols_q  <= cfg_wdata_i;
        default:   ; // no register here, drop the write
      endcase
    end
  end

  assign m_eff = (rows_q  > DIM_W'(DimCap)) ? DIM_W'(DimCap) : rows_q;
  assign k_eff = (inner_q > DIM_W'(DimCap)) ? DIM_W'(DimCap) : inner_q;
  assign n_eff = (cols_q  > DIM_W'(DimCap)) ? DIM_W'(DimCap) : cols_q;

  // ---------------------------------------------------------------------------
  // Command decode. Writes complete in the accepting cycle; out-of-range
  // writes and row requests are simply dropped.
  // ---------------------------------------------------------------------------
  assign go   = start & ~busy;
  assign wr_a = go & (mode_i == MODE_WR_A) &
                ({1'b0, row_index_i} < m_eff) & ({1'b0, col_index_i} < k_eff);
  assign wr_b = go & (mode_i == MODE_WR_B) &
                ({1'b0, row_index_i} < k_eff) & ({1'b0, col_index_i} < n_eff);
  assign row_go = go & (mode_i == MODE_ROW) &
                  ({1'b0, row_index_i} < m_eff) & (n_eff != '0);

  // Stores are laid out row-major with a stride of MAX_DIM.
  assign waddr   = AW'(32'(row_index_i) * MAX_DIM + 32'(col_index_i));
  assign a_raddr = AW'(32'(row_q) * MAX_DIM + 32'(kc_q));
  assign b_raddr = AW'(32'(kc_q) * MAX_DIM + 32'(jc_q));

  // ---------------------------------------------------------------------------
  // Row sequencer: walk columns j, and for each one the inner index k, issuing
  // one multiply-accumulate term per cycle. With K empty each column still gets
  // one slot whose product is forced to zero.
  // ---------------------------------------------------------------------------
  assign last_k = (k_eff == '0) | ({1'b0, kc_q} == k_eff - DIM_W'(1));
  assign last_j = ({1'b0, jc_q} == n_eff - DIM_W'(1));

  always_comb begin
    state_d = state_q;
    row_d   = row_q;
    kc_d    = kc_q;
    jc_d    = jc_q;
    unique case (state_q)
      ST_IDLE: begin
        if (row_go) begin
          state_d = ST_ISSUE;
          row_d   = row_index_i;
          kc_d    = '0;
          jc_d    = '0;
        end
      end
      ST_ISSUE: begin
        if (last_k) begin
          kc_d = '0;
          if (last_j) begin
            state_d = ST_DRAIN;
          end else begin
            jc_d = jc_q + IDX_W'(1);
          end
        end else begin
          kc_d = kc_q + IDX_W'(1);
        end
      end
      ST_DRAIN: begin
        // hold until the final column leaves the output register
        if (result_valid_o && last_of_row_o) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kc_q    <= '0;
      jc_q    <= '0;
    end else begin
      state_q <= state_d;
      kc_q    <= kc_d;
      jc_q    <= jc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

  assign busy = (state_q != ST_IDLE);

  always_comb begin
    tag.vld     = (state_q == ST_ISSUE);
    tag.first   = (kc_q == '0);
    tag.last    = last_k;
    tag.row_end = last_k & last_j;
    tag.zero    = (k_eff == '0);
    tag.col     = jc_q;
  end

  // ---------------------------------------------------------------------------
  // Stores and the shared datapath
  // ---------------------------------------------------------------------------
  mme_ram #(
    .WIDTH (VAL_W),
    .DEPTH (Depth),
    .AW    (AW)
  ) u_a_store (
    .clk_i   (clk_i),
    .we_i    (wr_a),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  mme_ram #(
    .WIDTH (VAL_W),
    .DEPTH (Depth),
    .AW    (AW)
  ) u_b_store (
    .clk_i   (clk_i),
    .we_i    (wr_b),
    .waddr_i (waddr),
    .wdata_i (element_value_i),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  mme_mac #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag),
    .a_i         (signed'(a_rdata)),
    .b_i         (signed'(b_rdata)),
    .out_vld_o   (result_valid_o),
    .out_col_o   (result_col_o),
    .out_value_o (product_value_o),
    .out_sat_o   (saturated_o),
    .out_last_o  (last_of_row_o)
  );

  `MME_ASSERT(a_result_while_busy, !result_valid_o || busy, "result item while idle")
  `MME_ASSERT_NEXT(a_row_end_idle, result_valid_o && last_of_row_o, !busy, "busy after last column")
  `MME_ASSERT_NEXT(a_row_starts, row_go, busy && (state_q == ST_ISSUE), "row request not started")

endmodule

`default_nettype wire

@@ dv/matrix_multiply_engine_test.sv @@
// Self-checking bench for the matrix multiply engine: shadows A, B and the size
// registers, predicts every row of C and compares each emitted element.
// Depends on mme_pkg and the matrix_multiply_engine RTL only.
`timescale 1ns / 100ps

module matrix_multiply_engine_test;
  import mme_pkg::*;

  localparam int DIM  = 16;  // store side length, row * DIM + col addressing
  localparam int FRAC = 16;  // Q16.16 fraction bits
  localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = 2'd3;
  // Longer than the longest row compute; wait this long before touching the
  // size registers.
  localparam int SETTLE_CYCLES = DIM * DIM + 40;
  // Cycles with no item accepted and no element emitted before giving up.
  localparam int STALL_LIMIT = 2000;
  localparam logic signed [71:0] SUM_TOP    = 72'sd2147483647;
  localparam logic signed [71:0] SUM_BOTTOM = -72'sd2147483648;

  typedef struct {
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    logic                    sat;
    logic                    last;
  } c_element_t;

  logic                    clk_i;
  logic                    rst_ni          = 1'b0;
  logic                    start           = 1'b0;
  logic                    busy;
  logic [MODE_W-1:0]       mode_i          = '0;
  logic [IDX_W-1:0]        row_index_i     = '0;
  logic [IDX_W-1:0]        col_index_i     = '0;
  logic signed [VAL_W-1:0] element_value_i = '0;
  logic                    cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_idx_i       = '0;
  logic [DIM_W-1:0]        cfg_wdata_i     = '0;
  logic                    result_valid_o;
  logic [IDX_W-1:0]        result_col_o;
  logic signed [VAL_W-1:0] product_value_o;
  logic                    saturated_o;
  logic                    last_of_row_o;

  // Shadow copies of the stores, with a flag per entry so that no compute
  // ever touches an entry the engine has not been given.
  logic signed [VAL_W-1:0] a_shadow [DIM*DIM];
  logic signed [VAL_W-1:0] b_shadow [DIM*DIM];
  bit                      a_written [DIM*DIM];
  bit                      b_written [DIM*DIM];
  logic [DIM_W-1:0]        rows_reg  = DIM_RESET;
  logic [DIM_W-1:0]        inner_reg = DIM_RESET;
  logic [DIM_W-1:0]        cols_reg  = DIM_RESET;

  c_element_t pending_c[$];  // predicted C elements, oldest first

  int idle_pct       = 0;
  int errors         = 0;
  int items_accepted = 0;
  int useful_items   = 0;  // writes that landed and rows that emitted
  int elements_seen  = 0;
  int clamped_seen   = 0;
  int size_settings  = 0;
  int stall_cycles   = 0;

  matrix_multiply_engine dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .mode_i          (mode_i),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .result_valid_o  (result_valid_o),
    .result_col_o    (result_col_o),
    .product_value_o (product_value_o),
    .saturated_o     (saturated_o),
    .last_of_row_o   (last_of_row_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Register values above 16 act as 16; zero makes the dimension empty.
  function automatic int eff_size(input logic [DIM_W-1:0] v);
    if (v > 5'd16) return DIM;
    return int'(v);
  endfunction

  // Work out row i of C from the shadow stores and queue its N elements.
  function automatic void predict_row(input int row);
    int                k_len;
    int                n_len;
    logic signed [71:0] sum;
    logic signed [71:0] scaled;
    logic signed [63:0] a_term;
    logic signed [63:0] b_term;
    c_element_t        elem;
    k_len = eff_size(inner_reg);
    n_len = eff_size(cols_reg);
    for (int j = 0; j < n_len; j++) begin
      sum = '0;
      // Exact sum of the K products; an empty inner size leaves it at zero.
      for (int kk = 0; kk < k_len; kk++) begin
        a_term = a_shadow[row * DIM + kk];
        b_term = b_shadow[kk * DIM + j];
        sum    = sum + a_term * b_term;
      end
      // Arithmetic shift truncates toward minus infinity, then clamp.
      scaled    = sum >>> FRAC;
      elem.col  = IDX_W'(j);
      elem.last = (j == n_len - 1);
      if (scaled > SUM_TOP) begin
        elem.sat   = 1'b1;
        elem.value = Q_MAX;
      end else if (scaled < SUM_BOTTOM) begin
        elem.sat   = 1'b1;
        elem.value = Q_MIN;
      end else begin
        elem.sat   = 1'b0;
        elem.value = scaled[VAL_W-1:0];
      end
      pending_c.push_back(elem);
    end
  endfunction

  // Apply one accepted item to the shadow state.
  function automatic void apply_command(input logic [MODE_W-1:0] mode,
                                        input logic [IDX_W-1:0] row,
                                        input logic [IDX_W-1:0] col,
                                        input logic signed [VAL_W-1:0] value);
    int m;
    int k;
    int n;
    m = eff_size(rows_reg);
    k = eff_size(inner_reg);
    n = eff_size(cols_reg);
    case (mode)
      MODE_WR_A: begin
        // A is M by K; anything outside is dropped
        if (row < m && col < k) begin
          a_shadow[row * DIM + col]  = value;
          a_written[row * DIM + col] = 1'b1;
          useful_items++;
        end
      end
      MODE_WR_B: begin
        // B is K by N
        if (row < k && col < n) begin
          b_shadow[row * DIM + col]  = value;
          b_written[row * DIM + col] = 1'b1;
          useful_items++;
        end
      end
      MODE_ROW: begin
        // a row at or above M, or an empty N, emits nothing
        if (row < m && n > 0) begin
          predict_row(row);
          useful_items++;
        end
      end
      default: ;  // unused mode does nothing
    endcase
  endfunction

  // Mostly modest Q16.16 values, with large and corner values mixed in so
  // that both clamping directions show up.
  function automatic logic signed [VAL_W-1:0] random_element();
    int v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = int'($urandom_range(0, 32'h7FFFF)) - 32'h40000;
      4, 5:       v = int'($urandom_range(0, 32'h1FF_FFFF)) - 32'h100_0000;
      6:          v = $urandom;
      7: begin
        v = int'($urandom_range(32'h2000_0000, 32'h7FFF_FFFF));
        if ($urandom_range(0, 1)) v = -v;
      end
      default: begin
        case ($urandom_range(0, 4))
          0:       v = Q_MAX;
          1:       v = Q_MIN;
          2:       v = 0;
          3:       v = -1;
          default: v = 1;
        endcase
      end
    endcase
    return v;
  endfunction

  // Send one item: idle the command side at random, then hold start until the
  // engine takes it. Busy is sampled at the falling edge, so the decision
  // never depends on update order at the rising edge. Start stays high on
  // return; the caller either drives the next item or drops start in the
  // same step.
  task automatic send_item(input logic [MODE_W-1:0] mode,
                           input logic [IDX_W-1:0] row,
                           input logic [IDX_W-1:0] col,
                           input logic signed [VAL_W-1:0] value);
    bit ready;
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start           <= 1'b1;
    mode_i          <= mode;
    row_index_i     <= row;
    col_index_i     <= col;
    element_value_i <= value;
    do begin
      @(negedge clk_i);
      ready = !busy;
      @(posedge clk_i);
    end while (!ready);
    items_accepted++;
    apply_command(mode, row, col, value);
  endtask

  // Write any A or B entry that row i of C would read and that is still
  // unwritten, then request the row. Unused fields of the request are random.
  task automatic issue_row(input logic [IDX_W-1:0] row);
    int m;
    int k;
    int n;
    m = eff_size(rows_reg);
    k = eff_size(inner_reg);
    n = eff_size(cols_reg);
    if (row < m) begin
      for (int kk = 0; kk < k; kk++) begin
        if (!a_written[row * DIM + kk])
          send_item(MODE_WR_A, row, IDX_W'(kk), random_element());
      end
      for (int kk = 0; kk < k; kk++) begin
        for (int j = 0; j < n; j++) begin
          if (!b_written[kk * DIM + j])
            send_item(MODE_WR_B, IDX_W'(kk), IDX_W'(j), random_element());
        end
      end
    end
    send_item(MODE_ROW, row, IDX_W'($urandom_range(0, 15)), $urandom);
  endtask

  // Drop start, wait for every predicted element, then let a request that
  // emits nothing run out before the sizes change.
  task automatic drain_and_settle();
    start <= 1'b0;
    while (pending_c.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write all three size registers, plus the spare index, which must be inert.
  task automatic program_sizes(input logic [DIM_W-1:0] m,
                               input logic [DIM_W-1:0] k,
                               input logic [DIM_W-1:0] n);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_ROWS;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    rows_reg     = m;
    cfg_idx_i   <= REG_INNER;
    cfg_wdata_i <= k;
    @(posedge clk_i);
    inner_reg    = k;
    cfg_idx_i   <= REG_COLS;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cols_reg     = n;
    cfg_idx_i   <= REG_SPARE;
    cfg_wdata_i <= DIM_W'($urandom_range(0, 31));
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    size_settings++;
  endtask

  // Full-scale operands: positive clamp, negative clamp and plain values.
  task automatic test_saturation_extremes();
    program_sizes(5'd2, 5'd2, 5'd2);
    send_item(MODE_WR_A, 4'd0, 4'd0, Q_MAX);
    send_item(MODE_WR_A, 4'd0, 4'd1, Q_MAX);
    send_item(MODE_WR_A, 4'd1, 4'd0, Q_MIN);
    send_item(MODE_WR_A, 4'd1, 4'd1, Q_MIN);
    send_item(MODE_WR_B, 4'd0, 4'd0, Q_MAX);
    send_item(MODE_WR_B, 4'd1, 4'd0, Q_MAX);
    send_item(MODE_WR_B, 4'd0, 4'd1, 32'sd1);
    send_item(MODE_WR_B, 4'd1, 4'd1, 32'sd0);
    send_item(MODE_ROW, 4'd0, 4'd15, 32'sd0);
    send_item(MODE_ROW, 4'd1, 4'd0, -32'sd1);
  endtask

  // Writes outside the sizes, the unused mode and rows beyond M must leave
  // the stores alone and emit nothing; a last row request proves it.
  task automatic test_ignored_items();
    send_item(MODE_WR_A, 4'd2, 4'd0, -32'sd1);
    send_item(MODE_WR_A, 4'd0, 4'd15, 32'sd0);
    send_item(MODE_WR_B, 4'd15, 4'd15, -32'sd1);
    send_item(MODE_WR_B, 4'd0, 4'd2, 32'sd12345);
    send_item(MODE_UNUSED, 4'd15, 4'd15, -32'sd1);
    send_item(MODE_ROW, 4'd15, 4'd15, Q_MAX);
    send_item(MODE_ROW, 4'd2, 4'd0, Q_MIN);
    send_item(MODE_ROW, 4'd0, 4'd0, 32'sd0);
  endtask

  // Empty inner size gives zeros; empty N or M gives no elements at all.
  task automatic test_empty_sizes();
    drain_and_settle();
    program_sizes(5'd2, 5'd0, 5'd2);
    send_item(MODE_ROW, 4'd1, 4'd0, 32'sd0);
    drain_and_settle();
    program_sizes(5'd2, 5'd2, 5'd0);
    send_item(MODE_ROW, 4'd0, 4'd0, 32'sd0);
    drain_and_settle();
    program_sizes(5'd0, 5'd2, 5'd2);
    send_item(MODE_WR_A, 4'd0, 4'd0, Q_MAX);
    send_item(MODE_ROW, 4'd0, 4'd0, 32'sd0);
  endtask

  // Size for a random phase: mostly 1..4, sometimes empty; rows may also take
  // a value of 16 to 31, which acts as 16 and stays cheap since only A grows.
  function automatic logic [DIM_W-1:0] pick_size(input bit allow_big);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1 && allow_big) return DIM_W'($urandom_range(16, 31));
    return DIM_W'($urandom_range(1, 4));
  endfunction

  // Mostly complete row requests on random data, the rest plain writes and
  // noise. Stop after the target of useful items, or give up if the sizes
  // allow few of them.
  task automatic random_stream(input int target);
    int first;
    int tries;
    int m;
    int k;
    int n;
    int pick;
    logic [MODE_W-1:0] mode;
    first = useful_items;
    tries = 0;
    while (useful_items - first < target && tries < 2 * target) begin
      tries++;
      m    = eff_size(rows_reg);
      k    = eff_size(inner_reg);
      n    = eff_size(cols_reg);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        issue_row(m > 0 ? IDX_W'($urandom_range(0, m - 1)) : IDX_W'($urandom_range(0, 15)));
      end else if (pick < 85) begin
        if ($urandom_range(0, 1))
          send_item(MODE_WR_A, IDX_W'($urandom_range(0, m > 0 ? m - 1 : 0)),
                    IDX_W'($urandom_range(0, k > 0 ? k - 1 : 0)), random_element());
        else
          send_item(MODE_WR_B, IDX_W'($urandom_range(0, k > 0 ? k - 1 : 0)),
                    IDX_W'($urandom_range(0, n > 0 ? n - 1 : 0)), random_element());
      end else begin
        mode = MODE_W'($urandom_range(0, 3));
        if (mode == MODE_ROW)
          issue_row(IDX_W'($urandom_range(0, 15)));
        else
          send_item(mode, IDX_W'($urandom_range(0, 15)), IDX_W'($urandom_range(0, 15)),
                    $urandom);
      end
    end
  endtask

  // Six phases: random small sizes and the full-width corners, under each
  // sender idling pattern.
  task automatic test_random_traffic();
    for (int ph = 0; ph < 6; ph++) begin
      drain_and_settle();
      case (ph)
        2:       program_sizes(5'd31, 5'd1, 5'd16);
        3:       program_sizes(5'd1, 5'd16, 5'd1);
        default: program_sizes(pick_size(1'b1), pick_size(1'b0), pick_size(1'b0));
      endcase
      case (ph % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 87;
        default: idle_pct = 34;
      endcase
      random_stream(20);
    end
    idle_pct = 0;
  endtask

  // Compare each emitted element against the oldest prediction. Outputs are
  // read at the rising edge, before the engine's own updates land.
  always @(posedge clk_i) begin
    c_element_t want;
    if (rst_ni && result_valid_o) begin
      elements_seen++;
      if (saturated_o) clamped_seen++;
      if (pending_c.size() == 0) begin
        $error("unexpected C element: result_col %0d product_value %0d",
               result_col_o, product_value_o);
        errors++;
      end else begin
        want = pending_c.pop_front();
        if (result_col_o !== want.col) begin
          $error("result_col: expected %0d, got %0d", want.col, result_col_o);
          errors++;
        end
        if (product_value_o !== want.value) begin
          $error("product_value: expected %0d, got %0d", want.value, product_value_o);
          errors++;
        end
        if (saturated_o !== want.sat) begin
          $error("saturated: expected %0b, got %0b", want.sat, saturated_o);
          errors++;
        end
        if (last_of_row_o !== want.last) begin
          $error("last_of_row: expected %0b, got %0b", want.last, last_of_row_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: restart the count whenever an item or element moves.
  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
      $display("matrix_multiply_engine_test failed");
      $finish;
    end
  end

  initial begin
    // Hold reset low, then release it at a rising edge.
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_saturation_extremes();
    test_ignored_items();
    test_empty_sizes();
    test_random_traffic();
    drain_and_settle();

    $display("run covered %0d accepted items (%0d landed or emitted) over %0d size settings",
             items_accepted, useful_items, size_settings);
    $display("checked %0d C elements, %0d of them clamped", elements_seen, clamped_seen);
    if (errors == 0) begin
      $display("matrix_multiply_engine_test passed");
    end else begin
      $display("matrix_multiply_engine_test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/mme_pkg.sv
design/mme_ram.sv
design/mme_mac.sv
design/matrix_multiply_engine.sv
dv/matrix_multiply_engine_test.sv
